// ----- design/apit_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apit_pkg : shared types and constants of the aging position item table
// Entry layout, cell commands, controller states and operation codes.
// ----------------------------------------------------------------------------
package apit_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int COORD_BITS  = 8;
	localparam int KIND_W      = 4;
	localparam int TIMER_W     = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_CNT_W   = 5;

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_LOOKUP = 3'd2;
	localparam logic [2:0] MODE_TICK   = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	localparam logic [TIMER_W-1:0] LIFETIME_RESET = 16'd1024;

	typedef struct packed {
		logic                  valid;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [KIND_W-1:0]     kind;
		logic [TIMER_W-1:0]    timer;
	} entry_t;

	typedef enum logic [3:0] {
		CMD_HOLD  = 4'b0001,
		CMD_ADD   = 4'b0010,
		CMD_SHIFT = 4'b0100,
		CMD_CLEAR = 4'b1000
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     push;
		entry_t   wdata;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage
`default_nettype wire

// ----- design/apit_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apit_if : channel interfaces of the aging position item table
// Command words in, result words out, and the lifetime register write channel.
// ----------------------------------------------------------------------------
interface apit_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [3:0] kind_in;

	modport source (output valid, mode, pos_x, pos_y, kind_in, input ready);
	modport sink   (input valid, mode, pos_x, pos_y, kind_in, output ready);
endinterface

interface apit_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [3:0] kind_out;
	logic       removed;
	logic       add_dropped;
	logic [4:0] expired_count;
	logic [4:0] occupancy;

	modport source (output valid, found, kind_out, removed, add_dropped, expired_count,
		occupancy, input ready);
	modport sink   (input valid, found, kind_out, removed, add_dropped, expired_count,
		occupancy, output ready);
endinterface

interface apit_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- design/apit_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apit_cell : one table slot
// Holds one entry; appends, clears, or takes its upper neighbour's entry on a
// shift, catching the recirculated word when it is the last occupied slot.
// ----------------------------------------------------------------------------
module apit_cell import apit_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  cell_cmd_t  cmd,
	input  wire        prev_valid,
	input  entry_t     next,
	output entry_t     cur
);

	logic   valid_q;
	entry_t data_q;
	logic   take_w;
	logic   take_n;

	always_comb begin
		take_w = 1'b0;
		take_n = 1'b0;
		unique case (cmd.op)
			CMD_ADD: begin
				take_w = !valid_q && prev_valid;
			end
			CMD_SHIFT: begin
				// last occupied slot catches the pushed word, the rest move down
				take_w = valid_q && !next.valid && cmd.push;
				take_n = !take_w;
			end
			CMD_HOLD, CMD_CLEAR: begin
				take_w = 1'b0;
			end
			default: begin
				take_w = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.op == CMD_CLEAR) begin
			valid_q <= 1'b0;
		end else if (take_w) begin
			valid_q <= 1'b1;
		end else if (take_n) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_w) begin
			data_q <= cmd.wdata;
		end else if (take_n) begin
			data_q <= next;
		end
	end

	always_comb begin
		cur       = data_q;
		cur.valid = valid_q;
	end

endmodule
`default_nettype wire

// ----- design/apit_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apit_ctrl : operation sequencer
// Takes command words, drives the cell row and walks the table through the
// head cell for remove, lookup and tick; holds the result word register.
// ----------------------------------------------------------------------------
module apit_ctrl import apit_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	apit_in_if.sink          in_ch,
	apit_out_if.source       out_ch,
	apit_cfg_if.sink         cfg,
	input  entry_t           head,
	output cell_cmd_t        cmd
);

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        fill_q, fill_d;
	logic [CNT_W-1:0]        scan_q, scan_d;
	logic [2:0]              op_q, op_d;
	logic [COORD_BITS-1:0]   key_x_q, key_x_d;
	logic [COORD_BITS-1:0]   key_y_q, key_y_d;
	logic                    found_q, found_d;
	logic [KIND_W-1:0]       kind_q, kind_d;
	logic                    rem_q, rem_d;
	logic [CNT_W-1:0]        exp_q, exp_d;
	logic                    drop_d;
	logic                    finish;
	logic [TIMER_W-1:0]      lifetime_q;
	logic                    acc;
	logic                    match;
	logic                    keep;
	logic [TIMER_W-1:0]      t_dec;

	logic                    out_valid_q;
	logic                    found_o_q;
	logic [KIND_W-1:0]       kind_o_q;
	logic                    rem_o_q;
	logic                    drop_o_q;
	logic [OUT_CNT_W-1:0]    exp_o_q;
	logic [OUT_CNT_W-1:0]    occ_o_q;

	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign acc         = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	assign match = (head.x == key_x_q) && (head.y == key_y_q);
	assign t_dec = (head.timer == '0) ? '0 : head.timer - 1'b1;

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		scan_d    = scan_q;
		op_d      = op_q;
		key_x_d   = key_x_q;
		key_y_d   = key_y_q;
		found_d   = found_q;
		kind_d    = kind_q;
		rem_d     = rem_q;
		exp_d     = exp_q;
		drop_d    = 1'b0;
		finish    = 1'b0;
		keep      = 1'b1;
		cmd.op    = CMD_HOLD;
		cmd.push  = 1'b0;
		cmd.wdata = head;
		unique case (state_q)
			ST_IDLE: begin
				found_d = 1'b0;
				kind_d  = '0;
				rem_d   = 1'b0;
				exp_d   = '0;
				if (acc) begin
					unique case (in_ch.mode)
						MODE_ADD: begin
							finish = 1'b1;
							if (fill_q < CNT_W'(TABLE_DEPTH)) begin
								cmd.op          = CMD_ADD;
								cmd.wdata.valid = 1'b1;
								cmd.wdata.x     = in_ch.pos_x[COORD_BITS-1:0];
								cmd.wdata.y     = in_ch.pos_y[COORD_BITS-1:0];
								cmd.wdata.kind  = in_ch.kind_in;
								cmd.wdata.timer = lifetime_q;
								fill_d          = fill_q + 1'b1;
							end else begin
								drop_d = 1'b1;
							end
						end
						MODE_REMOVE, MODE_LOOKUP, MODE_TICK: begin
							if (fill_q == '0) begin
								finish = 1'b1;
							end else begin
								state_d = ST_SCAN;
								scan_d  = fill_q;
								op_d    = in_ch.mode;
								key_x_d = in_ch.pos_x[COORD_BITS-1:0];
								key_y_d = in_ch.pos_y[COORD_BITS-1:0];
							end
						end
						MODE_CLEAR: begin
							cmd.op = CMD_CLEAR;
							fill_d = '0;
							finish = 1'b1;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// head entry leaves cell 0 and re-enters at the tail unless dropped
				cmd.op = CMD_SHIFT;
				unique case (op_q)
					MODE_TICK: begin
						cmd.wdata.timer = t_dec;
						if (t_dec == '0) begin
							keep  = 1'b0;
							exp_d = exp_q + 1'b1;
						end
					end
					MODE_REMOVE: begin
						if (match && !rem_q) begin
							keep  = 1'b0;
							rem_d = 1'b1;
						end
					end
					MODE_LOOKUP: begin
						if (match && !found_q) begin
							found_d = 1'b1;
							kind_d  = head.kind;
						end
					end
					default: begin
						keep = 1'b1;
					end
				endcase
				cmd.push = keep;
				if (!keep) begin
					fill_d = fill_q - 1'b1;
				end
				scan_d = scan_q - 1'b1;
				if (scan_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
					finish  = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			lifetime_q  <= LIFETIME_RESET;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				lifetime_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q  <= scan_d;
		op_q    <= op_d;
		key_x_q <= key_x_d;
		key_y_q <= key_y_d;
		found_q <= found_d;
		kind_q  <= kind_d;
		rem_q   <= rem_d;
		exp_q   <= exp_d;
		if (finish) begin
			found_o_q <= found_d;
			kind_o_q  <= kind_d;
			rem_o_q   <= rem_d;
			drop_o_q  <= drop_d;
			exp_o_q   <= OUT_CNT_W'(exp_d);
			occ_o_q   <= OUT_CNT_W'(fill_d);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.found         = found_o_q;
	assign out_ch.kind_out      = kind_o_q;
	assign out_ch.removed       = rem_o_q;
	assign out_ch.add_dropped   = drop_o_q;
	assign out_ch.expired_count = exp_o_q;
	assign out_ch.occupancy     = occ_o_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> head.valid)
		else $error("walk reached an empty head cell");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (scan_q != '0) && (scan_q <= fill_q))
		else $error("walk counter out of range");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !out_valid_q)
		else $error("result word pending while walking the table");
`endif

endmodule
`default_nettype wire

// ----- design/aging_position_item_table_top.sv -----
`default_nettype none
// Add, clear and unused modes: result word registered on acceptance.
// Remove, lookup and tick: result word registered when the walk ends (on acceptance when empty); the cell row
//   shifts one entry per cycle through the head cell, kept entries back in at the tail.
// A new command word is taken once the previous walk is done and the result
//   register is free or being read. Asynchronous reset empties the table,
//   drops any pending result and sets the lifetime register to 1024.
// ----------------------------------------------------------------------------
// aging_position_item_table_top : insertion-ordered table of aging items
// Row of entry cells with a sequencer that adds, removes, looks up, ages and
// clears entries keyed by position.
// ----------------------------------------------------------------------------
module aging_position_item_table_top import apit_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	apit_in_if.sink     in_ch,
	apit_out_if.source  out_ch,
	apit_cfg_if.sink    cfg
);

	entry_t    cells [TABLE_DEPTH];
	cell_cmd_t cmd;

	apit_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg),
		.head   (cells[0]),
		.cmd    (cmd)
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic   pv;
		entry_t nxt;

		if (i == 0) begin : g_first
			assign pv = 1'b1;
		end else begin : g_rest
			assign pv = cells[i-1].valid;
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cells[i+1];
		end

		apit_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (pv),
			.next       (nxt),
			.cur        (cells[i])
		);
	end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench : aging position item table
// Command words go in as bursts with random gaps while the result sink stalls
// on a changing pattern. Every result word is checked against a model of the
// table kept here, field by field and in order, over several lifetime settings.
// ----------------------------------------------------------------------------
module testbench;
	import apit_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	// mode codes the block does not use; they must leave the table alone
	localparam logic [2:0] MODE_SPARE5 = 3'd5;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [KIND_W-1:0]     kind;
		logic [TIMER_W-1:0]    timer;
	} slot_t;

	typedef struct packed {
		logic             found;
		logic [3:0]       kind_out;
		logic             removed;
		logic             add_dropped;
		logic [4:0]       expired_count;
		logic [4:0]       occupancy;
	} outcome_t;

	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_COMB, RX_TRICKLE} rx_style_t;

	logic clk = 1'b0;
	logic arst_n;

	apit_in_if  in_ch ();
	apit_out_if out_ch ();
	apit_cfg_if cfg ();

	aging_position_item_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always #6 clk = ~clk;

	slot_t              held[$];
	outcome_t           pending[$];
	logic [TIMER_W-1:0] lifetime_now;
	int                 errors = 0;
	int                 cycles = 0;
	int                 burst_left = 0;
	rx_style_t          rx_style;
	logic [7:0]         rx_count;

	// table model: applies one command word and returns the result word it gives
	function automatic outcome_t apply_word(input logic [2:0] mode,
			input logic [7:0] x, input logic [7:0] y, input logic [3:0] kind);
		outcome_t           r;
		slot_t              kept[$];
		slot_t              s;
		int                 hit;
		logic [TIMER_W-1:0] t;
		r = '0;
		hit = -1;
		case (mode)
			MODE_ADD: begin
				if (held.size() >= TABLE_DEPTH) begin
					r.add_dropped = 1'b1;
				end else begin
					s.x = x;
					s.y = y;
					s.kind = kind;
					s.timer = lifetime_now;
					held.push_back(s);
				end
			end
			MODE_REMOVE, MODE_LOOKUP: begin
				foreach (held[i]) begin
					if (hit < 0 && held[i].x == x && held[i].y == y)
						hit = i;
				end
				if (hit >= 0 && mode == MODE_REMOVE) begin
					held.delete(hit);
					r.removed = 1'b1;
				end else if (hit >= 0) begin
					r.found = 1'b1;
					r.kind_out = held[hit].kind;
				end
			end
			MODE_TICK: begin
				// timers saturate at zero, so a zero lifetime expires on the next tick
				foreach (held[i]) begin
					s = held[i];
					t = s.timer;
					if (t != 0)
						t = t - 1'b1;
					if (t == 0) begin
						r.expired_count = r.expired_count + 1'b1;
					end else begin
						s.timer = t;
						kept.push_back(s);
					end
				end
				held = kept;
			end
			MODE_CLEAR: begin
				held.delete();
			end
			default: ;
		endcase
		r.occupancy = 5'(held.size());
		return r;
	endfunction

	task automatic send_word(input logic [2:0] mode, input logic [7:0] x,
			input logic [7:0] y, input logic [3:0] kind);
		int gap;
		@(negedge clk);
		in_ch.valid   <= 1'b1;
		in_ch.mode    <= mode;
		in_ch.pos_x   <= x;
		in_ch.pos_y   <= y;
		in_ch.kind_in <= kind;
		do @(posedge clk); while (!in_ch.ready);
		pending.push_back(apply_word(mode, x, y, kind));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// stop sending and wait until every result word is back
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_lifetime(input logic [TIMER_W-1:0] value);
		settle();
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		lifetime_now = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// weighted random command; positions mostly reuse live entries so that
	// remove and lookup actually hit
	task automatic random_word(input int w_add, input int w_rem, input int w_look,
			input int w_tick, input int w_clr, input int w_spare);
		int         roll;
		int         pick;
		logic [2:0] mode;
		logic [7:0] x;
		logic [7:0] y;
		logic [3:0] kind;
		if ($urandom_range(0, 59) == 0)
			settle();
		roll = $urandom_range(0, w_add + w_rem + w_look + w_tick + w_clr + w_spare - 1);
		if (roll < w_add)
			mode = MODE_ADD;
		else if (roll < w_add + w_rem)
			mode = MODE_REMOVE;
		else if (roll < w_add + w_rem + w_look)
			mode = MODE_LOOKUP;
		else if (roll < w_add + w_rem + w_look + w_tick)
			mode = MODE_TICK;
		else if (roll < w_add + w_rem + w_look + w_tick + w_clr)
			mode = MODE_CLEAR;
		else begin
			case ($urandom_range(0, 2))
				0:       mode = MODE_SPARE5;
				1:       mode = MODE_SPARE6;
				default: mode = MODE_SPARE7;
			endcase
		end
		x = 8'($urandom);
		y = 8'($urandom);
		kind = 4'($urandom_range(0, 15));
		if (held.size() > 0 && ((mode == MODE_ADD) ? ($urandom_range(0, 3) == 0)
				: ($urandom_range(0, 3) != 0))) begin
			pick = $urandom_range(0, held.size() - 1);
			x = held[pick].x;
			y = held[pick].y;
		end
		send_word(mode, x, y, kind);
	endtask

	task automatic test_basics();
		send_word(MODE_LOOKUP, 8'h00, 8'h00, 4'h1);
		send_word(MODE_REMOVE, 8'h00, 8'h00, 4'h1);
		send_word(MODE_TICK,   8'h00, 8'h00, 4'h1);
		send_word(MODE_ADD,    8'h00, 8'h00, 4'h0);   // kind zero is stored as given
		send_word(MODE_ADD,    8'hFF, 8'hFF, 4'hF);
		send_word(MODE_ADD,    8'hFF, 8'hFF, 4'h7);   // duplicate position
		send_word(MODE_LOOKUP, 8'hFF, 8'hFF, 4'h0);
		send_word(MODE_LOOKUP, 8'h00, 8'h00, 4'h9);
		send_word(MODE_REMOVE, 8'hFF, 8'hFF, 4'h0);
		send_word(MODE_LOOKUP, 8'hFF, 8'hFF, 4'h0);
		send_word(MODE_SPARE5, 8'hFF, 8'h00, 4'hF);
		send_word(MODE_SPARE6, 8'h00, 8'hFF, 4'hF);
		send_word(MODE_SPARE7, 8'hFF, 8'hFF, 4'hF);
		send_word(MODE_TICK,   8'hAA, 8'h55, 4'h0);
		send_word(MODE_LOOKUP, 8'hAA, 8'h55, 4'h0);
		send_word(MODE_CLEAR,  8'h55, 8'hAA, 4'h0);
	endtask

	task automatic test_lifetime_floor();
		write_lifetime(16'h0000);
		send_word(MODE_ADD,  8'h12, 8'h34, 4'h3);
		send_word(MODE_TICK, 8'h00, 8'h00, 4'h0);
		write_lifetime(16'h0002);
		send_word(MODE_ADD,    8'h01, 8'h02, 4'h5);
		send_word(MODE_TICK,   8'h00, 8'h00, 4'h0);
		send_word(MODE_ADD,    8'h03, 8'h04, 4'h6);
		send_word(MODE_TICK,   8'h00, 8'h00, 4'h0);   // only the older entry goes
		send_word(MODE_LOOKUP, 8'h03, 8'h04, 4'h0);
		send_word(MODE_TICK,   8'h00, 8'h00, 4'h0);
	endtask

	task automatic test_crowded_table();
		write_lifetime(16'hFFFF);
		repeat (150) begin
			if (held.size() < TABLE_DEPTH && $urandom_range(0, 2) != 0)
				random_word(1, 0, 0, 0, 0, 0);
			else
				random_word(6, 2, 3, 1, 0, 1);
		end
	endtask

	task automatic test_fast_expiry();
		write_lifetime(16'h0001);
		repeat (50) random_word(4, 1, 2, 3, 0, 0);
		write_lifetime(16'h0002);
		repeat (50) random_word(4, 1, 2, 3, 0, 0);
		write_lifetime(16'h0003);
		repeat (50) random_word(4, 1, 2, 3, 0, 0);
		write_lifetime(16'($urandom_range(4, 9)));
		repeat (50) random_word(4, 1, 2, 3, 0, 0);
	endtask

	task automatic test_mixed_traffic();
		write_lifetime(16'($urandom_range(1, 65535)));
		repeat (66) random_word(4, 2, 3, 2, 1, 1);
		repeat (4) begin
			write_lifetime(16'($urandom_range(1, 30)));
			repeat (66) random_word(4, 2, 3, 2, 1, 1);
		end
	endtask

	task automatic check_field(input string name, input logic [4:0] want,
			input logic [4:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.found, out_ch.kind_out, out_ch.removed, out_ch.add_dropped,
				out_ch.expired_count, out_ch.occupancy};
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, actual %p", $time, got);
			end else begin
				want = pending.pop_front();
				check_field("found",         5'(want.found),       5'(got.found));
				check_field("kind_out",      5'(want.kind_out),    5'(got.kind_out));
				check_field("removed",       5'(want.removed),     5'(got.removed));
				check_field("add_dropped",   5'(want.add_dropped), 5'(got.add_dropped));
				check_field("expired_count", want.expired_count,   got.expired_count);
				check_field("occupancy",     want.occupancy,       got.occupancy);
			end
		end
	end

	// result sink: stall style is picked anew each time rx_count wraps, steady stretches included
	always @(negedge clk) begin
		rx_count = rx_count + 1'b1;
		if (rx_count == 0)
			rx_style = rx_style_t'($urandom_range(0, 3));
		case (rx_style)
			RX_STEADY: out_ch.ready <= 1'b1;
			RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
			RX_COMB:   out_ch.ready <= rx_count[1:0] != 2'b00;
			default:   out_ch.ready <= rx_count[2:0] == 3'b000;
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[aging_position_item_table_top] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.mode    = MODE_ADD;
		in_ch.pos_x   = '0;
		in_ch.pos_y   = '0;
		in_ch.kind_in = '0;
		cfg.valid     = 1'b0;
		cfg.data      = LIFETIME_RESET;
		out_ch.ready  = 1'b0;
		rx_count      = '0;
		rx_style      = RX_STEADY;
		lifetime_now  = LIFETIME_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_basics();
		test_lifetime_floor();
		test_crowded_table();
		test_fast_expiry();
		test_mixed_traffic();

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("[aging_position_item_table_top] OK");
		end else begin
			$display("[aging_position_item_table_top] ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/apit_pkg.sv
design/apit_if.sv
design/apit_cell.sv
design/apit_ctrl.sv
design/aging_position_item_table_top.sv
bench/testbench.sv
